// ===== design/sid_pkg.sv =====
`default_nettype none

package sid_pkg;

    // action codes on the result beat
    typedef enum logic [3:0] {
        ACT_ILLEGAL    = 4'd0,
        ACT_ECALL      = 4'd1,
        ACT_BREAK      = 4'd2,
        ACT_XRET       = 4'd3,
        ACT_WFI_STALL  = 4'd4,
        ACT_WFI_RESUME = 4'd5,
        ACT_FLUSH_ALL  = 4'd6,
        ACT_FLUSH_PAGE = 4'd7,
        ACT_CSR        = 4'd8
    } action_t;

    // trap cause codes
    localparam logic [3:0] CAUSE_NONE    = 4'd0;
    localparam logic [3:0] CAUSE_ILLEGAL = 4'd2;
    localparam logic [3:0] CAUSE_BREAK   = 4'd3;
    localparam logic [3:0] CAUSE_ECALL   = 4'd8;

    // privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // fixed instruction encodings
    localparam logic [6:0]  OP_SYSTEM    = 7'h73;
    localparam logic [31:0] I_ECALL      = 32'h0000_0073;
    localparam logic [31:0] I_EBREAK     = 32'h0010_0073;
    localparam logic [31:0] I_SRET       = 32'h1020_0073;
    localparam logic [31:0] I_MRET       = 32'h3020_0073;
    localparam logic [31:0] I_WFI        = 32'h1050_0073;
    localparam logic [31:0] FENCE_MASK   = 32'hFE00_7FFF;
    localparam logic [31:0] I_SFENCE_VMA = 32'h1200_0073;

    // funct3 codes
    localparam logic [2:0] F3_PRIV  = 3'd0;
    localparam logic [2:0] F3_RSVD  = 3'd4;

    // mstatus bit positions
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;
    localparam int ST_MPRV = 17;
    localparam int ST_TVM  = 20;
    localparam int ST_TW   = 21;
    localparam int ST_TSR  = 22;

    // one decoded result
    typedef struct packed {
        action_t     action;
        logic [3:0]  trap_cause;
        logic [63:0] new_status;
        logic [63:0] new_pc;
        logic [1:0]  new_privilege;
        logic [11:0] csr_address;
        logic [63:0] csr_operand;
        logic [1:0]  csr_kind;
        logic [4:0]  dest_index;
        logic [63:0] flush_address;
    } result_t;

endpackage

`default_nettype wire

// ===== design/sid_decode.sv =====
`default_nettype none

module sid_decode #(
    parameter int XLEN = 64
) (
    input  wire logic [31:0]      instruction,
    input  wire logic [1:0]       privilege,
    input  wire logic [63:0]      status_word,
    input  wire logic [63:0]      supervisor_return_pc,
    input  wire logic [63:0]      machine_return_pc,
    input  wire logic [63:0]      source_value,
    input  wire logic             irq_pending,
    output sid_pkg::result_t      result
);
    import sid_pkg::*;

    localparam logic [63:0] XMASK = {64{1'b1}} >> (64 - XLEN);

    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rd;
    logic        m_mode;
    logic        s_up;
    logic [63:0] rsv;
    logic [1:0]  mpp;

    assign f3     = instruction[14:12];
    assign rs1    = instruction[19:15];
    assign rd     = instruction[11:7];
    assign m_mode = (privilege == PRIV_M);
    assign s_up   = (privilege != PRIV_U);
    assign rsv    = source_value & XMASK;
    assign mpp    = status_word[ST_MPP +: 2];

    // decode in priority order
    always_comb
    begin
        result               = '0;
        result.action        = ACT_ILLEGAL;
        result.trap_cause    = CAUSE_ILLEGAL;
        result.new_status    = status_word;
        result.new_privilege = privilege;

        if (instruction[6:0] != OP_SYSTEM)
        begin
            result.action = ACT_ILLEGAL;
        end
        else if (instruction == I_ECALL)
        begin
            result.action     = ACT_ECALL;
            result.trap_cause = CAUSE_ECALL + {2'b00, privilege};
        end
        else if (instruction == I_EBREAK)
        begin
            result.action     = ACT_BREAK;
            result.trap_cause = CAUSE_BREAK;
        end
        else if (instruction == I_SRET && (m_mode || (s_up && !status_word[ST_TSR])))
        begin
            // restore SIE from SPIE, drop to SPP
            result.action                 = ACT_XRET;
            result.trap_cause             = CAUSE_NONE;
            result.new_privilege          = status_word[ST_SPP] ? PRIV_S : PRIV_U;
            result.new_status[ST_SIE]     = status_word[ST_SPIE];
            result.new_status[ST_SPIE]    = 1'b1;
            result.new_status[ST_SPP]     = 1'b0;
            result.new_status[ST_MPRV]    = 1'b0;
            result.new_pc                 = (supervisor_return_pc - 64'd4) & XMASK;
        end
        else if (instruction == I_MRET && m_mode)
        begin
            // restore MIE from MPIE, drop to MPP
            result.action                 = ACT_XRET;
            result.trap_cause             = CAUSE_NONE;
            result.new_privilege          = mpp;
            result.new_status[ST_MIE]     = status_word[ST_MPIE];
            result.new_status[ST_MPIE]    = 1'b1;
            result.new_status[ST_MPP +: 2] = 2'b00;
            if (mpp != PRIV_M)
            begin
                result.new_status[ST_MPRV] = 1'b0;
            end
            result.new_pc                 = (machine_return_pc - 64'd4) & XMASK;
        end
        else if (instruction == I_WFI && (m_mode || (s_up && !status_word[ST_TW])))
        begin
            result.action     = irq_pending ? ACT_WFI_RESUME : ACT_WFI_STALL;
            result.trap_cause = CAUSE_NONE;
        end
        else if (f3 == F3_PRIV)
        begin
            if ((instruction & FENCE_MASK) == I_SFENCE_VMA
                && (m_mode || (s_up && !status_word[ST_TVM])))
            begin
                result.trap_cause = CAUSE_NONE;
                if (rs1 != 5'd0)
                begin
                    result.action        = ACT_FLUSH_PAGE;
                    result.flush_address = rsv;
                end
                else
                begin
                    result.action = ACT_FLUSH_ALL;
                end
            end
        end
        else if (f3 != F3_RSVD)
        begin
            // Zicsr request: immediate forms carry rs1 as a 5-bit value
            result.action      = ACT_CSR;
            result.trap_cause  = CAUSE_NONE;
            result.csr_address = instruction[31:20];
            result.csr_operand = f3[2] ? {59'd0, rs1} : rsv;
            result.csr_kind    = f3[1:0] - 2'd1;
            result.dest_index  = rd;
        end
    end

endmodule

`default_nettype wire

// ===== design/system_instruction_decode.sv =====
// Channel   Handshake          Payload
// -------   ----------------   --------------------------------------------------
// command   start / busy       instruction, privilege, status_word,
//                              supervisor_return_pc, machine_return_pc,
//                              source_value, irq_pending
// result    done (strobe)      action, trap_cause, new_status, new_pc,
//                              new_privilege, csr_address, csr_operand,
//                              csr_kind, dest_index, flush_address
//
// One beat is accepted every cycle; busy stays low.
// A beat passes the command register, the decode logic and the result register in that order.
// A single decode stage sits between the two registers.
// rst_n clears both valid flags; payload registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
`default_nettype none

module system_instruction_decode #(
    parameter int XLEN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] instruction,
    input  wire logic [1:0]  privilege,
    input  wire logic [63:0] status_word,
    input  wire logic [63:0] supervisor_return_pc,
    input  wire logic [63:0] machine_return_pc,
    input  wire logic [63:0] source_value,
    input  wire logic        irq_pending,
    output logic             done,
    output logic [3:0]       action,
    output logic [3:0]       trap_cause,
    output logic [63:0]      new_status,
    output logic [63:0]      new_pc,
    output logic [1:0]       new_privilege,
    output logic [11:0]      csr_address,
    output logic [63:0]      csr_operand,
    output logic [1:0]       csr_kind,
    output logic [4:0]       dest_index,
    output logic [63:0]      flush_address
);
    import sid_pkg::*;

    logic        in_valid_reg;
    logic [31:0] insn_reg;
    logic [1:0]  priv_reg;
    logic [63:0] status_reg;
    logic [63:0] sepc_reg;
    logic [63:0] mepc_reg;
    logic [63:0] rsv_reg;
    logic        irq_reg;
    logic        accept;

    result_t     result_next;
    result_t     result_reg;
    logic        done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // hold command valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // capture command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            insn_reg   <= instruction;
            priv_reg   <= privilege;
            status_reg <= status_word;
            sepc_reg   <= supervisor_return_pc;
            mepc_reg   <= machine_return_pc;
            rsv_reg    <= source_value;
            irq_reg    <= irq_pending;
        end
    end

    sid_decode #(
        .XLEN (XLEN)
    ) u_decode (
        .instruction          (insn_reg),
        .privilege            (priv_reg),
        .status_word          (status_reg),
        .supervisor_return_pc (sepc_reg),
        .machine_return_pc    (mepc_reg),
        .source_value         (rsv_reg),
        .irq_pending          (irq_reg),
        .result               (result_next)
    );

    // advance result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    // capture decoded result
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done          = done_reg;
    assign action        = result_reg.action;
    assign trap_cause    = result_reg.trap_cause;
    assign new_status    = result_reg.new_status;
    assign new_pc        = result_reg.new_pc;
    assign new_privilege = result_reg.new_privilege;
    assign csr_address   = result_reg.csr_address;
    assign csr_operand   = result_reg.csr_operand;
    assign csr_kind      = result_reg.csr_kind;
    assign dest_index    = result_reg.dest_index;
    assign flush_address = result_reg.flush_address;

endmodule

`default_nettype wire

// ===== design/sid_checker.sv =====
`default_nettype none

module sid_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [3:0]  action,
    input  wire logic [3:0]  trap_cause,
    input  wire logic [63:0] new_pc,
    input  wire logic [11:0] csr_address,
    input  wire logic [63:0] flush_address
);
    import sid_pkg::*;

    // every accepted command beat yields a result through the command and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result beat missing two cycles after accept");

    // no result beat without an earlier accepted command beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result beat without a command beat");

    // ecall cause tracks privilege, a breakpoint reports its own cause
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((action != ACT_ECALL || trap_cause >= CAUSE_ECALL)
                  && (action != ACT_BREAK || trap_cause == CAUSE_BREAK)))
        else $error("trap cause does not match action");

    // return pc only on xret, flush address only on page flush
    a_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action != ACT_XRET && action != ACT_FLUSH_PAGE)
        |-> (new_pc == 64'd0 && flush_address == 64'd0))
        else $error("operand driven for wrong action");

    // csr address only on csr requests
    a_csr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action != ACT_CSR) |-> (csr_address == 12'd0))
        else $error("csr address driven outside a csr request");

endmodule

bind system_instruction_decode sid_checker u_sid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .action        (action),
    .trap_cause    (trap_cause),
    .new_pc        (new_pc),
    .csr_address   (csr_address),
    .flush_address (flush_address)
);

`default_nettype wire
